[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers clocked on aclk
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define TTE_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("assertion failed");

// checked on every edge, reset included
`define TTE_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("assertion failed");

`endif

[rtl/tte_pkg.sv]
// ---------------------------------------------------------------------------
// tte_pkg
// types and character codes of the text terminal escape engine
// ---------------------------------------------------------------------------
package tte_pkg;

    typedef struct packed {
        logic       opcode;
        logic [7:0] char_code;
        logic [3:0] read_row;
        logic [3:0] read_col;
    } in_word_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [3:0] cursor_column;
        logic [3:0] cursor_line;
        logic       inserting;
    } out_word_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MODIFY,
        ST_CLEAR,
        ST_FINISH
    } state_t;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_CARET,
        ESC_DIGIT
    } esc_t;

    typedef enum logic [1:0] {
        OP_PUT,
        OP_ERASE,
        OP_READ
    } op_t;

    localparam logic OPC_FEED = 1'b0;
    localparam logic OPC_READ = 1'b1;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_U     = 8'h75;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_O     = 8'h6F;

endpackage

[rtl/text_terminal_escape_engine.sv]
// ---------------------------------------------------------------------------
// text_terminal_escape_engine
// character terminal: byte stream with caret escapes drawn into a screen
// store of ROWS rows, one row per memory word, with cursor and insert mode
// ---------------------------------------------------------------------------
//  channel | ports                     | word
//  --------+---------------------------+---------------------------------
//  input   | s_valid s_ready s_data    | opcode char_code read_row read_col
//  result  | m_valid m_ready m_data    | cell_char cursor_column/line inserting
//
//  one word at a time: accept, decode, row read-modify-write, result load
//  cell read, print and erase go through decode, row read-modify-write and result
//  load; cursor and mode bytes skip the row access; clear screen writes one row word per cycle
//  reset clears the row valid flags at once; an unwritten row reads as spaces
//  a stalled result holds in the output register; the next word is accepted
//  meanwhile and waits at result load until the register is free
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module text_terminal_escape_engine #(
    parameter int ROWS = 10,
    parameter int COLS = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tte_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tte_pkg::out_word_t m_data
);

    localparam int ROW_W = $clog2(ROWS);
    localparam int COL_W = $clog2(COLS);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLS - 1);

    typedef logic [COLS-1:0][7:0] row_t;

    localparam row_t BLANK_ROW = {COLS{tte_pkg::CH_SPACE}};

    row_t mem [ROWS];

    tte_pkg::state_t    state_reg, state_next;
    tte_pkg::esc_t      esc_reg, esc_next;
    tte_pkg::op_t       op_reg, op_next;
    tte_pkg::in_word_t  item_reg, item_next;
    tte_pkg::out_word_t out_reg, out_next;
    logic               m_valid_reg, m_valid_next;
    logic [COL_W-1:0]   cur_x_reg, cur_x_next;
    logic [ROW_W-1:0]   cur_y_reg, cur_y_next;
    logic               insert_reg, insert_next;
    logic [3:0]         first_digit_reg, first_digit_next;
    logic [7:0]         put_char_reg, put_char_next;
    logic [7:0]         cell_reg, cell_next;
    logic [ROW_W-1:0]   clr_row_reg, clr_row_next;
    logic [ROWS-1:0]    row_valid_reg;
    row_t               rd_data_reg;
    logic               rd_valid_reg;

    logic             rd_en;
    logic [ROW_W-1:0] rd_addr;
    logic             wr_en;
    logic [ROW_W-1:0] wr_addr;
    row_t             wr_data;
    row_t             src_row;
    row_t             new_row;
    logic [7:0]       b;
    logic             is_digit;
    logic             is_print;
    logic             plain;

    assign s_ready = (state_reg == tte_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign b        = item_reg.char_code;
    assign is_digit = b inside {[tte_pkg::CH_0:tte_pkg::CH_9]};
    assign is_print = b inside {[tte_pkg::CH_SPACE:tte_pkg::CH_TILDE]};

    // row word before the pending edit; a never-written row reads as spaces
    assign src_row = rd_valid_reg ? rd_data_reg : BLANK_ROW;

    always_comb begin
        new_row = src_row;
        case (op_reg)
            tte_pkg::OP_PUT: begin
                if (insert_reg) begin
                    for (int i = 1; i < COLS; i++) begin
                        if (COL_W'(i) > cur_x_reg) begin
                            new_row[i] = src_row[i-1];
                        end
                    end
                end
                new_row[cur_x_reg] = put_char_reg;
            end
            tte_pkg::OP_ERASE: begin
                for (int i = 0; i < COLS; i++) begin
                    if (COL_W'(i) >= cur_x_reg) begin
                        new_row[i] = tte_pkg::CH_SPACE;
                    end
                end
            end
            default: begin
                new_row = src_row;
            end
        endcase
    end

    always_comb begin
        state_next       = state_reg;
        esc_next         = esc_reg;
        op_next          = op_reg;
        item_next        = item_reg;
        out_next         = out_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        insert_next      = insert_reg;
        first_digit_next = first_digit_reg;
        put_char_next    = put_char_reg;
        cell_next        = cell_reg;
        clr_row_next     = clr_row_reg;
        rd_en            = 1'b0;
        rd_addr          = cur_y_reg;
        wr_en            = 1'b0;
        wr_addr          = cur_y_reg;
        wr_data          = new_row;
        plain            = 1'b0;

        case (state_reg)
            tte_pkg::ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    cell_next  = '0;
                    state_next = tte_pkg::ST_DECODE;
                end
            end
            tte_pkg::ST_DECODE: begin
                state_next = tte_pkg::ST_FINISH;
                if (item_reg.opcode == tte_pkg::OPC_READ) begin
                    if (item_reg.read_row < 4'(ROWS) && item_reg.read_col < 4'(COLS)) begin
                        op_next    = tte_pkg::OP_READ;
                        rd_en      = 1'b1;
                        rd_addr    = item_reg.read_row[ROW_W-1:0];
                        state_next = tte_pkg::ST_MODIFY;
                    end
                end else if (b == tte_pkg::CH_NL) begin
                    esc_next = tte_pkg::ESC_NONE;
                end else begin
                    case (esc_reg)
                        tte_pkg::ESC_CARET: begin
                            esc_next = tte_pkg::ESC_NONE;
                            case (b)
                                tte_pkg::CH_C: begin
                                    clr_row_next = '0;
                                    state_next   = tte_pkg::ST_CLEAR;
                                end
                                tte_pkg::CH_E: begin
                                    op_next    = tte_pkg::OP_ERASE;
                                    rd_en      = 1'b1;
                                    state_next = tte_pkg::ST_MODIFY;
                                end
                                tte_pkg::CH_H: begin
                                    cur_x_next = '0;
                                    cur_y_next = '0;
                                end
                                tte_pkg::CH_B: begin
                                    cur_x_next = '0;
                                end
                                tte_pkg::CH_R: begin
                                    if (cur_x_reg != COL_LAST) begin
                                        cur_x_next = cur_x_reg + 1'b1;
                                    end
                                end
                                tte_pkg::CH_L: begin
                                    if (cur_x_reg != '0) begin
                                        cur_x_next = cur_x_reg - 1'b1;
                                    end
                                end
                                tte_pkg::CH_D: begin
                                    if (cur_y_reg != ROW_LAST) begin
                                        cur_y_next = cur_y_reg + 1'b1;
                                    end
                                end
                                tte_pkg::CH_U: begin
                                    if (cur_y_reg != '0) begin
                                        cur_y_next = cur_y_reg - 1'b1;
                                    end
                                end
                                tte_pkg::CH_I: begin
                                    insert_next = 1'b1;
                                end
                                tte_pkg::CH_O: begin
                                    insert_next = 1'b0;
                                end
                                tte_pkg::CH_CARET: begin
                                    put_char_next = tte_pkg::CH_CARET;
                                    op_next       = tte_pkg::OP_PUT;
                                    rd_en         = 1'b1;
                                    state_next    = tte_pkg::ST_MODIFY;
                                end
                                default: begin
                                    if (is_digit) begin
                                        first_digit_next = b[3:0];
                                        esc_next         = tte_pkg::ESC_DIGIT;
                                    end
                                end
                            endcase
                        end
                        tte_pkg::ESC_DIGIT: begin
                            esc_next = tte_pkg::ESC_NONE;
                            if (is_digit) begin
                                cur_y_next = (first_digit_reg < 4'(ROWS)) ?
                                             first_digit_reg[ROW_W-1:0] : ROW_LAST;
                                cur_x_next = (b[3:0] < 4'(COLS)) ? b[COL_W-1:0] : COL_LAST;
                            end else begin
                                plain = 1'b1;
                            end
                        end
                        default: begin
                            plain = 1'b1;
                        end
                    endcase
                    if (plain) begin
                        if (b == tte_pkg::CH_CARET) begin
                            esc_next = tte_pkg::ESC_CARET;
                        end else if (is_print) begin
                            put_char_next = b;
                            op_next       = tte_pkg::OP_PUT;
                            rd_en         = 1'b1;
                            state_next    = tte_pkg::ST_MODIFY;
                        end
                    end
                end
            end
            tte_pkg::ST_MODIFY: begin
                state_next = tte_pkg::ST_FINISH;
                if (op_reg == tte_pkg::OP_READ) begin
                    cell_next = src_row[item_reg.read_col[COL_W-1:0]];
                end else begin
                    wr_en = 1'b1;
                    if (op_reg == tte_pkg::OP_PUT && cur_x_reg != COL_LAST) begin
                        cur_x_next = cur_x_reg + 1'b1;
                    end
                end
            end
            tte_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_row_reg;
                wr_data = BLANK_ROW;
                if (clr_row_reg == ROW_LAST) begin
                    state_next = tte_pkg::ST_FINISH;
                end else begin
                    clr_row_next = clr_row_reg + 1'b1;
                end
            end
            tte_pkg::ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    out_next.cell_char     = cell_reg;
                    out_next.cursor_column = 4'(cur_x_reg);
                    out_next.cursor_line   = 4'(cur_y_reg);
                    out_next.inserting     = insert_reg;
                    state_next             = tte_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= tte_pkg::ST_IDLE;
            esc_reg         <= tte_pkg::ESC_NONE;
            m_valid_reg     <= 1'b0;
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            insert_reg      <= 1'b0;
            first_digit_reg <= '0;
            row_valid_reg   <= '0;
        end else begin
            state_reg       <= state_next;
            esc_reg         <= esc_next;
            m_valid_reg     <= m_valid_next;
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            insert_reg      <= insert_next;
            first_digit_reg <= first_digit_next;
            if (wr_en) begin
                row_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        item_reg     <= item_next;
        out_reg      <= out_next;
        put_char_reg <= put_char_next;
        cell_reg     <= cell_next;
        clr_row_reg  <= clr_row_next;
    end

    // screen store, one row per word
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
    end

    `TTE_ASSERT(a_cursor_on_screen, (cur_x_reg <= COL_LAST && cur_y_reg <= ROW_LAST))
    `TTE_ASSERT(a_result_from_finish, ($rose(m_valid_reg) |-> $past(state_reg) == tte_pkg::ST_FINISH))
    `TTE_ASSERT(a_clear_fills_rows, ((state_reg == tte_pkg::ST_CLEAR && clr_row_reg == ROW_LAST) |=> (&row_valid_reg)))
    `TTE_ASSERT(a_read_keeps_cursor, ((state_reg == tte_pkg::ST_DECODE && item_reg.opcode == tte_pkg::OPC_READ) |=> ($stable(cur_x_reg) && $stable(cur_y_reg) && $stable(esc_reg))))

endmodule

[verif/tb.sv]
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the text terminal escape engine: a shadow screen
// with cursor, insert mode and escape state predicts every result word,
// while random gaps and stalls on both channels stress the handshakes
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int ROWS = 10;
    localparam int COLS = 10;
    localparam int WORD_COUNT = 1850;

    class terminal_shadow;
        logic [7:0]         cells [ROWS][COLS];
        logic [3:0]         col;
        logic [3:0]         row;
        logic               ins;
        tte_pkg::esc_t      phase;
        logic [3:0]         held_row;
        tte_pkg::out_word_t pending_views [$];
        int                 errors;

        function new();
            blank_screen();
            col = '0;
            row = '0;
            ins = 1'b0;
            phase = tte_pkg::ESC_NONE;
            held_row = '0;
            errors = 0;
        endfunction

        function void blank_screen();
            foreach (cells[r, c]) cells[r][c] = tte_pkg::CH_SPACE;
        endfunction

        function bit is_digit(logic [7:0] ch);
            return ch >= tte_pkg::CH_0 && ch <= tte_pkg::CH_9;
        endfunction

        function void put_char(logic [7:0] ch);
            if (ins) begin
                for (int i = COLS - 1; i > col; i--) cells[row][i] = cells[row][i - 1];
            end
            cells[row][col] = ch;
            if (col < COLS - 1) col++;
        endfunction

        function void plain(logic [7:0] ch);
            if (ch == tte_pkg::CH_CARET) phase = tte_pkg::ESC_CARET;
            else if (ch >= tte_pkg::CH_SPACE && ch <= tte_pkg::CH_TILDE) put_char(ch);
        endfunction

        function void note_word(tte_pkg::in_word_t w);
            tte_pkg::out_word_t view;
            logic [7:0]         ch;
            logic [7:0]         digit_val;
            view = '0;
            ch = w.char_code;
            digit_val = ch - tte_pkg::CH_0;
            if (w.opcode == tte_pkg::OPC_FEED) begin
                if (ch == tte_pkg::CH_NL) begin
                    phase = tte_pkg::ESC_NONE;
                end else if (phase == tte_pkg::ESC_CARET) begin
                    phase = tte_pkg::ESC_NONE;
                    case (ch)
                        tte_pkg::CH_C: blank_screen();
                        tte_pkg::CH_E: begin
                            for (int i = col; i < COLS; i++) begin
                                cells[row][i] = tte_pkg::CH_SPACE;
                            end
                        end
                        tte_pkg::CH_H: begin
                            col = '0;
                            row = '0;
                        end
                        tte_pkg::CH_B: col = '0;
                        tte_pkg::CH_R: if (col < COLS - 1) col++;
                        tte_pkg::CH_D: if (row < ROWS - 1) row++;
                        tte_pkg::CH_L: if (col > 0) col--;
                        tte_pkg::CH_U: if (row > 0) row--;
                        tte_pkg::CH_I: ins = 1'b1;
                        tte_pkg::CH_O: ins = 1'b0;
                        tte_pkg::CH_CARET: put_char(tte_pkg::CH_CARET);
                        default: begin
                            if (is_digit(ch)) begin
                                held_row = 4'(digit_val);
                                phase = tte_pkg::ESC_DIGIT;
                            end
                        end
                    endcase
                end else if (phase == tte_pkg::ESC_DIGIT) begin
                    phase = tte_pkg::ESC_NONE;
                    if (is_digit(ch)) begin
                        row = (held_row < ROWS) ? held_row : 4'(ROWS - 1);
                        col = (digit_val < COLS) ? 4'(digit_val) : 4'(COLS - 1);
                    end else begin
                        plain(ch);
                    end
                end else begin
                    plain(ch);
                end
            end else if (w.read_row < ROWS && w.read_col < COLS) begin
                view.cell_char = cells[w.read_row][w.read_col];
            end
            view.cursor_column = col;
            view.cursor_line = row;
            view.inserting = ins;
            pending_views.push_back(view);
        endfunction

        function void check_word(tte_pkg::out_word_t got);
            tte_pkg::out_word_t want;
            if (pending_views.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: char %h col %0d line %0d ins %0d",
                             got.cell_char, got.cursor_column, got.cursor_line, got.inserting);
                return;
            end
            want = pending_views.pop_front();
            if (got.cell_char !== want.cell_char || got.cursor_column !== want.cursor_column ||
                got.cursor_line !== want.cursor_line || got.inserting !== want.inserting) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch: expected char %h col %0d line %0d ins %0d",
                             want.cell_char, want.cursor_column, want.cursor_line,
                             want.inserting);
                    $display("          actual   char %h col %0d line %0d ins %0d",
                             got.cell_char, got.cursor_column, got.cursor_line,
                             got.inserting);
                end
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    tte_pkg::in_word_t  s_data = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    tte_pkg::out_word_t m_data;

    terminal_shadow shadow = new();
    int             sent = 0;
    bit             steady = 1'b0;

    text_terminal_escape_engine #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(tte_pkg::in_word_t w);
        int gap;
        bit rdy;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= w;
        forever begin
            @(negedge aclk);
            rdy = s_ready;
            @(posedge aclk);
            if (rdy) break;
        end
        shadow.note_word(w);
        sent++;
    endtask

    task automatic send_feed(logic [7:0] ch);
        tte_pkg::in_word_t w;
        w.opcode = tte_pkg::OPC_FEED;
        w.char_code = ch;
        w.read_row = 4'($urandom_range(0, 15));
        w.read_col = 4'($urandom_range(0, 15));
        send_word(w);
    endtask

    task automatic send_read(logic [3:0] r, logic [3:0] c);
        tte_pkg::in_word_t w;
        w.opcode = tte_pkg::OPC_READ;
        w.char_code = 8'($urandom_range(0, 255));
        w.read_row = r;
        w.read_col = c;
        send_word(w);
    endtask

    task automatic send_random_read();
        logic [3:0] r;
        logic [3:0] c;
        r = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, ROWS - 1));
        c = 4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, COLS - 1));
        send_read(r, c);
    endtask

    task automatic send_escape();
        logic [7:0] actions [11];
        int         pick;
        actions = '{tte_pkg::CH_E, tte_pkg::CH_H, tte_pkg::CH_B, tte_pkg::CH_R, tte_pkg::CH_L,
                    tte_pkg::CH_D, tte_pkg::CH_U, tte_pkg::CH_I, tte_pkg::CH_O,
                    tte_pkg::CH_CARET, tte_pkg::CH_R};
        pick = $urandom_range(0, 99);
        send_feed(tte_pkg::CH_CARET);
        if ($urandom_range(0, 9) == 0) send_random_read();
        if (pick < 30) begin
            send_feed(tte_pkg::CH_0 + 8'($urandom_range(0, 9)));
            if ($urandom_range(0, 9) == 0) send_random_read();
            send_feed(tte_pkg::CH_0 + 8'($urandom_range(0, 9)));
        end else if (pick < 32) begin
            send_feed(tte_pkg::CH_C);
        end else begin
            send_feed(actions[$urandom_range(0, 10)]);
        end
    endtask

    task automatic send_noise();
        int pick;
        pick = $urandom_range(0, 3);
        case (pick)
            0: send_feed(8'($urandom_range(0, 255)));
            1: begin
                send_feed(tte_pkg::CH_CARET);
                send_feed(8'($urandom_range(0, 255)));
            end
            2: begin
                send_feed(tte_pkg::CH_CARET);
                send_feed(tte_pkg::CH_0 + 8'($urandom_range(0, 9)));
                send_feed(8'($urandom_range(0, 255)));
            end
            default: begin
                send_feed(tte_pkg::CH_CARET);
                send_feed(tte_pkg::CH_NL);
            end
        endcase
    endtask

    // result side with random stalls
    initial begin
        bit                 took;
        tte_pkg::out_word_t seen;
        int                 hold;
        hold = 0;
        forever begin
            @(negedge aclk);
            took = m_valid && m_ready;
            seen = m_data;
            @(posedge aclk);
            if (took) shadow.check_word(seen);
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                m_ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) hold = idle_gap();
            end
        end
    end

    initial begin
        int pick;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_read(4'd15, 4'd15);
        send_feed(8'h41);
        send_feed(tte_pkg::CH_TILDE);
        send_feed(8'hFF);
        send_feed(tte_pkg::CH_CARET);
        send_feed(tte_pkg::CH_I);
        send_feed(tte_pkg::CH_SPACE);
        send_feed(tte_pkg::CH_CARET);
        send_feed(tte_pkg::CH_9);
        send_feed(tte_pkg::CH_9);
        send_feed(tte_pkg::CH_CARET);
        send_feed(tte_pkg::CH_CARET);
        send_feed(tte_pkg::CH_CARET);
        send_feed(8'h7A);
        send_feed(tte_pkg::CH_CARET);
        send_feed(tte_pkg::CH_0 + 8'd3);
        send_feed(8'h78);
        send_feed(tte_pkg::CH_CARET);
        send_feed(tte_pkg::CH_NL);
        send_feed(tte_pkg::CH_CARET);
        send_feed(tte_pkg::CH_E);
        send_feed(tte_pkg::CH_CARET);
        send_feed(tte_pkg::CH_O);
        send_read(4'd9, 4'd9);
        send_read(4'd3, 4'd0);

        while (sent < WORD_COUNT) begin
            if ($urandom_range(0, 149) == 0) steady = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 20) send_random_read();
            else if (pick < 55) send_feed(8'($urandom_range(tte_pkg::CH_SPACE, tte_pkg::CH_TILDE)));
            else if (pick < 88) send_escape();
            else send_noise();
        end
        s_valid <= 1'b0;

        while (shadow.pending_views.size() != 0) @(posedge aclk);
        repeat (4 * ROWS) @(posedge aclk);
        if (shadow.errors == 0 && shadow.pending_views.size() == 0) begin
            $display("[text_terminal_escape_engine] OK");
        end else begin
            $display("[text_terminal_escape_engine] ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[text_terminal_escape_engine] ERROR");
        $finish;
    end

endmodule
